### src/lrsf_pkg.sv
`default_nettype none

package lrsf_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int MAX_RESULTS     = 32;

  localparam int ID_W       = 16;
  localparam int BYTES_W    = 16;
  localparam int TIME_W     = 48;
  localparam int CAP_W      = 24;
  localparam int QLIM_W     = 6;
  localparam int BPM_W      = CAP_W - 3;
  localparam int ERR_W      = 32;
  localparam int NUM_W      = ERR_W + 2;
  localparam int DIV_W      = NUM_W - 1;
  localparam int DCNT_W     = $clog2(DIV_W + 1);
  localparam int PROD_W     = DIV_W + 10;
  localparam int CNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CAP_W;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QLIMIT   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    KIND_ACCEPT  = 2'd0,
    KIND_DROP    = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_e;

endpackage

`default_nettype wire

### src/lrsf_in_if.sv
`default_nettype none

interface lrsf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [lrsf_pkg::ID_W-1:0]    pkt_id;
  logic [lrsf_pkg::BYTES_W-1:0] packet_bytes;
  logic [lrsf_pkg::TIME_W-1:0]  time_us;

  modport source (output valid, action, pkt_id, packet_bytes, time_us, input ready);
  modport sink   (input valid, action, pkt_id, packet_bytes, time_us, output ready);
endinterface

`default_nettype wire

### src/lrsf_out_if.sv
`default_nettype none

interface lrsf_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [lrsf_pkg::ID_W-1:0]   out_id;
  logic [lrsf_pkg::TIME_W-1:0] arrival_us;
  logic                        last;

  modport source (output valid, kind, out_id, arrival_us, last, input ready);
  modport sink   (input valid, kind, out_id, arrival_us, last, output ready);
endinterface

`default_nettype wire

### src/lrsf_ram.sv
`default_nettype none

module lrsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### src/link_rate_shaper_fifo.sv
// Enqueue: an accepted item goes through 33 divider steps, one multiply and one add; the
// result is registered once the output is free. A zero-delay enqueue skips the divider, a
// drop skips all three. Tick: each queue entry examined takes one registered memory read
// and one compare; a tick stops at the first entry not yet due or at the result limit.
// Reset is asynchronous and clears pointers, occupancy, carried error and both registers;
// the queue memory is not cleared, as only occupied entries are read.
`default_nettype none

module link_rate_shaper_fifo #(
  parameter int QUEUE_DEPTH = lrsf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  lrsf_in_if.sink                                item_i,
  lrsf_out_if.source                             result_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [lrsf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [lrsf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import lrsf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (OCC_W > QLIM_W) ? OCC_W : QLIM_W;
  localparam int ENT_W = ID_W + TIME_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DROP,
    ST_TRD,
    ST_TCHK,
    ST_TFIN
  } state_e;

  state_e              state_q, state_d;
  logic [CAP_W-1:0]    cap_q, cap_d;
  logic [QLIM_W-1:0]   lim_q, lim_d;
  logic [PTR_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic [OCC_W-1:0]    occ_q, occ_d;
  logic [ERR_W-1:0]    err_q, err_d;
  logic [TIME_W-1:0]   tail_exit_q, tail_exit_d;
  logic [ID_W-1:0]     id_q, id_d;
  logic [TIME_W-1:0]   time_q, time_d;
  logic [DIV_W-1:0]    dvd_q, dvd_d;
  logic [BPM_W-1:0]    rem_q, rem_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic                pend_valid_q, pend_valid_d;
  logic [ID_W-1:0]     pend_id_q, pend_id_d;
  logic [TIME_W-1:0]   pend_time_q, pend_time_d;
  logic                out_valid_q, out_valid_d;
  kind_e               out_kind_q, out_kind_d;
  logic [ID_W-1:0]     out_id_q, out_id_d;
  logic [TIME_W-1:0]   out_arr_q, out_arr_d;
  logic                out_last_q, out_last_d;

  logic [BPM_W-1:0]    bpm, half;
  logic [NUM_W-1:0]    num;
  logic                num_pos;
  logic [ERR_W-1:0]    sum_be;
  logic                full;
  logic [BPM_W:0]      shifted, sub;
  logic                ge;
  logic [BPM_W-1:0]    rem_next;
  logic [PROD_W-1:0]   prod;
  logic [TIME_W-1:0]   start;
  logic [TIME_W:0]     sum;
  logic [TIME_W-1:0]   exit_us;
  logic                due, out_free;
  logic [PTR_W-1:0]    tail_nxt, head_nxt;
  logic                ram_we, ram_re;
  logic [ENT_W-1:0]    ram_rdata;

  lrsf_ram #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i ({id_q, exit_us}),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign item_i.ready        = (state_q == ST_IDLE);
  assign result_o.valid      = out_valid_q;
  assign result_o.kind       = out_kind_q;
  assign result_o.out_id     = out_id_q;
  assign result_o.arrival_us = out_arr_q;
  assign result_o.last       = out_last_q;

  always_comb begin
    bpm     = cap_q[CAP_W-1:3];
    half    = {1'b0, bpm[BPM_W-1:1]};
    num     = NUM_W'(item_i.packet_bytes) + {{(NUM_W-ERR_W){err_q[ERR_W-1]}}, err_q}
              + NUM_W'(half);
    num_pos = !num[NUM_W-1] && (num != '0);
    sum_be  = ERR_W'(item_i.packet_bytes) + err_q;
    full    = (occ_q >= OCC_W'(QUEUE_DEPTH))
              || ((lim_q != '0) && (CMP_W'(occ_q) >= CMP_W'(lim_q)));

    shifted  = {rem_q, dvd_q[DIV_W-1]};
    sub      = shifted - {1'b0, bpm};
    ge       = (shifted >= {1'b0, bpm});
    rem_next = ge ? sub[BPM_W-1:0] : shifted[BPM_W-1:0];

    prod = {dvd_q, 10'd0} - PROD_W'({dvd_q, 4'd0}) - PROD_W'({dvd_q, 3'd0});

    start   = ((occ_q != '0) && (tail_exit_q > time_q)) ? tail_exit_q : time_q;
    sum     = {1'b0, start} + (TIME_W + 1)'(prod_q);
    exit_us = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

    due      = (occ_q != '0) && (time_q >= ram_rdata[TIME_W-1:0]);
    out_free = !out_valid_q || result_o.ready;
    tail_nxt = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
    head_nxt = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
  end

  always_comb begin
    state_d      = state_q;
    cap_d        = cap_q;
    lim_d        = lim_q;
    head_d       = head_q;
    tail_d       = tail_q;
    occ_d        = occ_q;
    err_d        = err_q;
    tail_exit_d  = tail_exit_q;
    id_d         = id_q;
    time_d       = time_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    dcnt_d       = dcnt_q;
    prod_d       = prod_q;
    n_d          = n_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    pend_time_d  = pend_time_q;
    out_valid_d  = out_valid_q && !result_o.ready;
    out_kind_d   = out_kind_q;
    out_id_d     = out_id_q;
    out_arr_d    = out_arr_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CAPACITY: cap_d = cfg_data_i[CAP_W-1:0];
        REG_QLIMIT:   lim_d = cfg_data_i[QLIM_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (item_i.valid) begin
          id_d   = item_i.pkt_id;
          time_d = item_i.time_us;
          if (item_i.action == ACT_TICK) begin
            n_d     = '0;
            state_d = ST_TRD;
          end else if (full) begin
            state_d = ST_DROP;
          end else if (bpm == '0) begin
            dvd_d   = '0;
            state_d = ST_MUL;
          end else if (!num_pos) begin
            dvd_d   = '0;
            err_d   = sum_be;
            state_d = ST_MUL;
          end else begin
            dvd_d   = num[DIV_W-1:0];
            rem_d   = '0;
            dcnt_d  = DCNT_W'(DIV_W);
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        dvd_d  = {dvd_q[DIV_W-2:0], ge};
        rem_d  = rem_next;
        dcnt_d = dcnt_q - DCNT_W'(1);
        if (dcnt_q == DCNT_W'(1)) begin
          err_d   = ERR_W'(rem_next) - ERR_W'(half);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = prod;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (out_free) begin
          ram_we      = 1'b1;
          tail_d      = tail_nxt;
          occ_d       = occ_q + OCC_W'(1);
          tail_exit_d = exit_us;
          out_valid_d = 1'b1;
          out_kind_d  = KIND_ACCEPT;
          out_id_d    = id_q;
          out_arr_d   = exit_us;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_DROP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_DROP;
          out_id_d    = id_q;
          out_arr_d   = '0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_TRD: begin
        ram_re  = 1'b1;
        state_d = ST_TCHK;
      end
      ST_TCHK: begin
        if (!due) begin
          if (!pend_valid_q) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            out_valid_d  = 1'b1;
            out_kind_d   = KIND_RELEASE;
            out_id_d     = pend_id_q;
            out_arr_d    = pend_time_q;
            out_last_d   = 1'b1;
            pend_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end else if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_kind_d  = KIND_RELEASE;
            out_id_d    = pend_id_q;
            out_arr_d   = pend_time_q;
            out_last_d  = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_id_d    = ram_rdata[ENT_W-1:TIME_W];
          pend_time_d  = ram_rdata[TIME_W-1:0];
          head_d       = head_nxt;
          occ_d        = occ_q - OCC_W'(1);
          n_d          = n_q + CNT_W'(1);
          state_d      = (n_q == CNT_W'(MAX_RESULTS - 1)) ? ST_TFIN : ST_TRD;
        end
      end
      ST_TFIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_RELEASE;
          out_id_d     = pend_id_q;
          out_arr_d    = pend_time_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cap_q        <= '0;
      lim_q        <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      occ_q        <= '0;
      err_q        <= '0;
      n_q          <= '0;
      dcnt_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cap_q        <= cap_d;
      lim_q        <= lim_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      occ_q        <= occ_d;
      err_q        <= err_d;
      n_q          <= n_d;
      dcnt_q       <= dcnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_exit_q <= tail_exit_d;
    id_q        <= id_d;
    time_q      <= time_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    prod_q      <= prod_d;
    pend_id_q   <= pend_id_d;
    pend_time_q <= pend_time_d;
    out_kind_q  <= out_kind_d;
    out_id_q    <= out_id_d;
    out_arr_q   <= out_arr_d;
    out_last_q  <= out_last_d;
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(QUEUE_DEPTH))
    else $error("Occupancy exceeds the queue depth.");

  a_release_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CNT_W'(MAX_RESULTS))
    else $error("Tick released more items than allowed.");

  a_push_from_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q > $past(occ_q) |-> $past(state_q) == ST_ADD)
    else $error("Occupancy grew outside the enqueue commit.");

  a_pend_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == ST_TRD || state_q == ST_TCHK || state_q == ST_TFIN))
    else $error("Pending release held outside a tick.");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KIND_DROP) |-> (out_arr_q == '0 && out_last_q))
    else $error("Dropped item carries an arrival time.");

endmodule

`default_nettype wire
